FILE: design/es2cd_pkg.sv
`timescale 1ns / 1ps
package es2cd_pkg;

    localparam int MAX_YEAR_DEF = 9999;
    localparam int EPOCH_YEAR   = 1970;

    // days from 0001-01-01 to 1970-01-01
    localparam logic [21:0] EPOCH_ORDINAL = 22'd719162;

    localparam logic [9:0]  DAY_UNITS  = 10'd675;     // 86400 / 128
    localparam logic [17:0] DAYS_400Y  = 18'd146097;
    localparam logic [15:0] DAYS_100Y  = 16'd36524;
    localparam logic [10:0] DAYS_4Y    = 11'd1461;
    localparam logic [8:0]  DAYS_1Y    = 9'd365;

    // reciprocals for division by constants, q0 = (x * m) >> shift, off by at most one
    localparam logic [30:0] RECIP_675    = 31'((64'd1 << 40) / 675);
    localparam logic [26:0] RECIP_60     = 27'((64'd1 << 32) / 60);
    localparam logic [20:0] RECIP_3600   = 21'((64'd1 << 32) / 3600);
    localparam logic [29:0] RECIP_7      = 30'((64'd1 << 32) / 7);
    localparam logic [14:0] RECIP_146097 = 15'((64'd1 << 32) / 146097);
    localparam logic [21:0] RECIP_1461   = 22'((64'd1 << 32) / 1461);

    function automatic logic [63:0] leaps_upto(input logic [63:0] n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic logic [63:0] days_before(input logic [63:0] y);
        return 64'd365 * (y - 64'(EPOCH_YEAR)) + leaps_upto(y - 64'd1)
               - leaps_upto(64'(EPOCH_YEAR - 1));
    endfunction

    function automatic logic [37:0] last_second(input int max_year);
        return 38'(days_before(64'(max_year) + 64'd1) * 64'd86400 - 64'd1);
    endfunction

    // first day of year for each month
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (m >= 4'd2))
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

    typedef struct packed {
        logic [37:0] t;
        logic        oor;
        logic [21:0] qd;
        logic [21:0] days;
        logic [16:0] sod;
        logic [21:0] z;
        logic [22:0] d4;
        logic [11:0] q60;
        logic [4:0]  q3600;
        logic [20:0] q7;
        logic [4:0]  q400;
        logic [11:0] min_total;
        logic [4:0]  hour;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [2:0]  weekday;
        logic [4:0]  n400;
        logic [17:0] r400;
        logic [1:0]  n100;
        logic [15:0] r100;
        logic [4:0]  q4;
        logic [4:0]  n4;
        logic [10:0] r4;
        logic [8:0]  doy;
        logic        leap;
        logic [12:0] yr;
        logic [3:0]  month;
        logic [4:0]  day;
    } pipe_t;

endpackage

FILE: design/es2cd_if.sv
`timescale 1ns / 1ps
interface es2cd_in_if;
    logic        valid;
    logic        ready;
    logic [37:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface es2cd_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [12:0] years_since_1900;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic [8:0]  day_of_year;
    logic [2:0]  weekday;
    logic        out_of_range;

    modport source (output valid, output second, output minute, output hour,
                    output years_since_1900, output month_index, output day_of_month,
                    output day_of_year, output weekday, output out_of_range,
                    input ready);
    modport sink   (input valid, input second, input minute, input hour,
                    input years_since_1900, input month_index, input day_of_month,
                    input day_of_year, input weekday, input out_of_range,
                    output ready);
endinterface

FILE: design/epoch_seconds_to_civil_date_core.sv
`timescale 1ns / 1ps
// channel | direction | payload
// epoch   | in        | epoch_seconds
// date    | out       | second, minute, hour, years_since_1900, month_index,
//         |           | day_of_month, day_of_year, weekday, out_of_range
//
// eleven register stages; one transaction enters per cycle unless the output stalls
// the last stage is the output register; the pipeline advances when it is empty or taken
// a stall freezes every stage, so nothing is dropped or repeated
// rst_n clears the valid bits only; no state survives between transactions
module epoch_seconds_to_civil_date_core
    import es2cd_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    es2cd_in_if.sink     epoch,
    es2cd_out_if.source  date
);

    localparam int NS = 11;
    localparam logic [37:0] LIMIT = last_second(MAX_YEAR);

    pipe_t           s_reg  [NS];
    pipe_t           s_next [NS];
    logic [NS-1:0]   v_reg;
    logic            advance;

    logic [61:0] p675;
    logic [31:0] r675;
    logic [43:0] p60;
    logic [37:0] p3600;
    logic [52:0] p7;
    logic [36:0] p400;
    logic [16:0] r60;
    logic [16:0] r3600;
    logic [22:0] r7;
    logic [21:0] r400;
    logic [37:0] p1461;
    logic [15:0] r1461;
    logic [1:0]  n1;
    logic [3:0]  mcount;

    assign advance     = !v_reg[NS-1] || date.ready;
    assign epoch.ready = advance;

    always_comb
    begin
        for (int k = 1; k < NS; k++)
        begin
            s_next[k] = s_reg[k-1];
        end

        // input capture and range check
        s_next[0]     = '0;
        s_next[0].t   = epoch.epoch_seconds;
        s_next[0].oor = epoch.epoch_seconds > LIMIT;

        // days estimate from t / 128 / 675
        p675         = 62'(s_reg[0].t[37:7]) * 62'(RECIP_675);
        s_next[1].qd = p675[61:40];

        // correct days, seconds of day
        r675 = 32'(s_reg[1].t[37:7]) - 32'(s_reg[1].qd) * 32'(DAY_UNITS);
        if (r675 >= 32'(DAY_UNITS))
        begin
            s_next[2].days = s_reg[1].qd + 22'd1;
            r675           = r675 - 32'(DAY_UNITS);
        end
        else
        begin
            s_next[2].days = s_reg[1].qd;
        end
        s_next[2].sod = {r675[9:0], s_reg[1].t[6:0]};

        // quotient estimates
        s_next[3].z     = s_reg[2].days + EPOCH_ORDINAL;
        s_next[3].d4    = 23'(s_reg[2].days) + 23'd4;
        p60             = 44'(s_reg[2].sod) * 44'(RECIP_60);
        p3600           = 38'(s_reg[2].sod) * 38'(RECIP_3600);
        p7              = 53'(s_next[3].d4) * 53'(RECIP_7);
        p400            = 37'(s_next[3].z) * 37'(RECIP_146097);
        s_next[3].q60   = p60[43:32];
        s_next[3].q3600 = p3600[36:32];
        s_next[3].q7    = p7[52:32];
        s_next[3].q400  = p400[36:32];

        // quotient corrections
        r60   = s_reg[3].sod - 17'(s_reg[3].q60) * 17'd60;
        r3600 = s_reg[3].sod - 17'(17'(s_reg[3].q3600) * 17'd3600);
        r7    = s_reg[3].d4 - 23'(s_reg[3].q7) * 23'd7;
        r400  = s_reg[3].z - 22'(22'(s_reg[3].q400) * 22'(DAYS_400Y));
        if (r60 >= 17'd60)
        begin
            s_next[4].min_total = s_reg[3].q60 + 12'd1;
            s_next[4].second    = 6'(r60 - 17'd60);
        end
        else
        begin
            s_next[4].min_total = s_reg[3].q60;
            s_next[4].second    = 6'(r60);
        end
        s_next[4].hour    = (r3600 >= 17'd3600) ? s_reg[3].q3600 + 5'd1 : s_reg[3].q3600;
        s_next[4].weekday = (r7 >= 23'd7) ? 3'(r7 - 23'd7) : 3'(r7);
        if (r400 >= 22'(DAYS_400Y))
        begin
            s_next[4].n400 = s_reg[3].q400 + 5'd1;
            s_next[4].r400 = 18'(r400 - 22'(DAYS_400Y));
        end
        else
        begin
            s_next[4].n400 = s_reg[3].q400;
            s_next[4].r400 = 18'(r400);
        end

        // minute, century within the 400-year cycle
        s_next[5].minute = 6'(s_reg[4].min_total - 12'(s_reg[4].hour) * 12'd60);
        if (s_reg[4].r400 >= 18'(3 * DAYS_100Y))
        begin
            s_next[5].n100 = 2'd3;
        end
        else if (s_reg[4].r400 >= 18'(2 * DAYS_100Y))
        begin
            s_next[5].n100 = 2'd2;
        end
        else if (s_reg[4].r400 >= 18'(DAYS_100Y))
        begin
            s_next[5].n100 = 2'd1;
        end
        else
        begin
            s_next[5].n100 = 2'd0;
        end
        s_next[5].r100 = 16'(s_reg[4].r400 - 18'(s_next[5].n100) * 18'(DAYS_100Y));

        // four-year group estimate
        p1461        = 38'(s_reg[5].r100) * 38'(RECIP_1461);
        s_next[6].q4 = p1461[36:32];

        r1461 = s_reg[6].r100 - 16'(16'(s_reg[6].q4) * 16'(DAYS_4Y));
        if (r1461 >= 16'(DAYS_4Y))
        begin
            s_next[7].n4 = s_reg[6].q4 + 5'd1;
            s_next[7].r4 = 11'(r1461 - 16'(DAYS_4Y));
        end
        else
        begin
            s_next[7].n4 = s_reg[6].q4;
            s_next[7].r4 = 11'(r1461);
        end

        // year within the group; the last day of a group belongs to its fourth year
        if (s_reg[7].r4 >= 11'(3 * DAYS_1Y))
        begin
            n1 = 2'd3;
        end
        else if (s_reg[7].r4 >= 11'(2 * DAYS_1Y))
        begin
            n1 = 2'd2;
        end
        else if (s_reg[7].r4 >= 11'(DAYS_1Y))
        begin
            n1 = 2'd1;
        end
        else
        begin
            n1 = 2'd0;
        end
        s_next[8].doy  = 9'(s_reg[7].r4 - 11'(n1) * 11'(DAYS_1Y));
        s_next[8].leap = (n1 == 2'd3) && ((s_reg[7].n4 != 5'd24) || (s_reg[7].n100 == 2'd3));
        s_next[8].yr   = 13'(16'(s_reg[7].n400) * 16'd400 + 16'(s_reg[7].n100) * 16'd100
                             + 16'(s_reg[7].n4) * 16'd4 + 16'(n1) + 16'd1 - 16'd1900);

        // month by counting passed month starts
        mcount = 4'd0;
        for (int m = 1; m < 12; m++)
        begin
            if (s_reg[8].doy >= month_start(4'(m), s_reg[8].leap))
            begin
                mcount = mcount + 4'd1;
            end
        end
        s_next[9].month = mcount;

        // day of month, out-of-range clears the date
        s_next[10].day = 5'(s_reg[9].doy - month_start(s_reg[9].month, s_reg[9].leap) + 9'd1);
        if (s_reg[9].oor)
        begin
            s_next[10].yr      = '0;
            s_next[10].month   = '0;
            s_next[10].day     = '0;
            s_next[10].doy     = '0;
            s_next[10].weekday = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[NS-2:0], epoch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NS; k++)
            begin
                s_reg[k] <= s_next[k];
            end
        end
    end

    assign date.valid            = v_reg[NS-1];
    assign date.second           = s_reg[NS-1].second;
    assign date.minute           = s_reg[NS-1].minute;
    assign date.hour             = s_reg[NS-1].hour;
    assign date.years_since_1900 = s_reg[NS-1].yr;
    assign date.month_index      = s_reg[NS-1].month;
    assign date.day_of_month     = s_reg[NS-1].day;
    assign date.day_of_year      = s_reg[NS-1].doy;
    assign date.weekday          = s_reg[NS-1].weekday;
    assign date.out_of_range     = s_reg[NS-1].oor;

endmodule

FILE: dv/es2cd_checker.sv
`timescale 1ns / 1ps
module es2cd_checker
    import es2cd_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    es2cd_in_if  epoch,
    es2cd_out_if date,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [12:0] years_since_1900;
        logic [3:0]  month_index;
        logic [4:0]  day_of_month;
        logic [8:0]  day_of_year;
        logic [2:0]  weekday;
        logic        out_of_range;
    } civil_date_t;

    civil_date_t dates_due[$];

    function automatic longint unsigned leap_count(input longint unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic longint unsigned year_start_day(input longint unsigned y);
        return 365 * (y - 1970) + leap_count(y - 1) - leap_count(1969);
    endfunction

    function automatic bit is_leap(input longint unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic civil_date_t convert_epoch(input logic [37:0] secs);
        civil_date_t     r;
        longint unsigned t, last, days, y, rem, len;
        int              m;
        t = secs;
        r = '0;
        last = year_start_day(MAX_YEAR + 1) * 86400 - 1;
        r.second = t % 60;
        r.minute = (t / 60) % 60;
        r.hour   = (t / 3600) % 24;
        if (t > last)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        days = t / 86400;
        y = 1970 + days / 366;
        while (year_start_day(y + 1) <= days)
            y++;
        rem = days - year_start_day(y);
        r.years_since_1900 = 13'(y - 1900);
        r.day_of_year = 9'(rem);
        m = 0;
        while (m < 11)
        begin
            case (m)
                1:       len = is_leap(y) ? 29 : 28;
                3, 5, 8, 10: len = 30;
                default: len = 31;
            endcase
            if (rem < len)
                break;
            rem -= len;
            m++;
        end
        r.month_index = 4'(m);
        r.day_of_month = 5'(rem + 1);
        r.weekday = 3'((days + 4) % 7);
        return r;
    endfunction

    assign pending = dates_due.size();

    always @(posedge clk)
    begin
        civil_date_t want;
        if (rst_n && epoch.valid && epoch.ready)
            dates_due.push_back(convert_epoch(epoch.epoch_seconds));
        if (rst_n && date.valid && date.ready)
        begin
            if (dates_due.size() == 0)
            begin
                $error("date transaction with nothing expected");
                errors++;
            end
            else
            begin
                want = dates_due.pop_front();
                if (date.second !== want.second) begin
                    $error("second exp %0d got %0d", want.second, date.second); errors++; end
                if (date.minute !== want.minute) begin
                    $error("minute exp %0d got %0d", want.minute, date.minute); errors++; end
                if (date.hour !== want.hour) begin
                    $error("hour exp %0d got %0d", want.hour, date.hour); errors++; end
                if (date.years_since_1900 !== want.years_since_1900) begin
                    $error("years_since_1900 exp %0d got %0d", want.years_since_1900,
                           date.years_since_1900); errors++; end
                if (date.month_index !== want.month_index) begin
                    $error("month_index exp %0d got %0d", want.month_index,
                           date.month_index); errors++; end
                if (date.day_of_month !== want.day_of_month) begin
                    $error("day_of_month exp %0d got %0d", want.day_of_month,
                           date.day_of_month); errors++; end
                if (date.day_of_year !== want.day_of_year) begin
                    $error("day_of_year exp %0d got %0d", want.day_of_year,
                           date.day_of_year); errors++; end
                if (date.weekday !== want.weekday) begin
                    $error("weekday exp %0d got %0d", want.weekday, date.weekday); errors++; end
                if (date.out_of_range !== want.out_of_range) begin
                    $error("out_of_range exp %0d got %0d", want.out_of_range,
                           date.out_of_range); errors++; end
            end
        end
    end

    initial errors = 0;

endmodule

FILE: dv/tb_epoch_seconds_to_civil_date_core.sv
`timescale 1ns / 1ps
module tb_epoch_seconds_to_civil_date_core
    import es2cd_pkg::*;
();

    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   stall_cycles;
    logic [37:0] last_sec;

    es2cd_in_if  epoch ();
    es2cd_out_if date ();

    epoch_seconds_to_civil_date_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .epoch (epoch),
        .date  (date)
    );

    es2cd_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .epoch   (epoch),
        .date    (date),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver stalls at random
    always @(posedge clk)
        date.ready <= ($urandom_range(99) >= recv_idle_pct);

    // counts cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((epoch.valid && epoch.ready) || (date.valid && date.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > WATCHDOG)
        begin
            $display("tb_epoch_seconds_to_civil_date_core: done, errors");
            $finish;
        end
    end

    function automatic logic [37:0] day_start(input longint unsigned y);
        return 38'((365 * (y - 1970) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400
                    - 477) * 86400);
    endfunction

    task automatic send_epoch(input logic [37:0] secs);
        while ($urandom_range(99) < send_idle_pct)
        begin
            epoch.valid <= 1'b0;
            @(posedge clk);
        end
        epoch.valid <= 1'b1;
        epoch.epoch_seconds <= secs;
        @(posedge clk);
        while (!epoch.ready)
            @(posedge clk);
    endtask

    task automatic random_epoch();
        longint unsigned y;
        int              k;
        k = $urandom_range(9);
        if (k < 4)
        begin
            // near a year boundary
            y = $urandom_range(MAX_YEAR_DEF + 1, 1971);
            send_epoch(day_start(y) + 38'($urandom_range(200)) - 38'd100);
        end
        else if (k < 6)
        begin
            // around the end of february
            y = $urandom_range(MAX_YEAR_DEF, 1970);
            send_epoch(day_start(y) + 38'(58 * 86400) + 38'($urandom_range(2 * 86400)));
        end
        else if (k < 7)
            send_epoch(last_sec + 38'($urandom_range(2000)) - 38'd1000);
        else if (k < 8)
            send_epoch(38'({$urandom(), $urandom()}));
        else
            send_epoch(38'({$urandom(), $urandom()} % 64'(last_sec)));
    endtask

    initial
    begin
        longint unsigned dirs[$];
        last_sec = last_second(MAX_YEAR_DEF);
        rst_n = 1'b0;
        epoch.valid = 1'b0;
        epoch.epoch_seconds = '0;
        date.ready = 1'b0;
        send_idle_pct = 6;
        recv_idle_pct = 84;
        stall_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dirs = '{0, 1, 59, 60, 3599, 3600, 86399, 86400, 951782400, 951868800,
                 4107456000, 4107542400, 4107542399, 978307199, 978220800,
                 38'h3FFFFFFFFF, 38'h2AAAAAAAAA, 38'h1555555555, 253402300799,
                 253402300800, 253402214400, 2147483647, 2147483648};
        foreach (dirs[i])
            send_epoch(38'(dirs[i]));

        for (int i = 0; i < 500; i++)
            random_epoch();
        // hold off until the pipeline drains
        epoch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        send_idle_pct = 84;
        recv_idle_pct = 6;
        for (int i = 0; i < 500; i++)
            random_epoch();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 530; i++)
            random_epoch();

        epoch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_epoch_seconds_to_civil_date_core: done, clean");
        else
            $display("tb_epoch_seconds_to_civil_date_core: done, errors");
        $finish;
    end

endmodule
